>>> src/bfa_pkg.sv
// Shared types and codes for the best-fit partition allocator.
`default_nettype none

package bfa_pkg;

  // Fixed field widths of the stream items.
  localparam int ACTION_W = 2;
  localparam int FIELD_SIZE_W = 16;
  localparam int OWNER_W = 8;
  localparam int BLOCK_W = 4;
  localparam int CODE_W = 2;

  // Input action codes.
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

  // Result codes.
  localparam logic [CODE_W-1:0] RES_OK    = 2'd0;
  localparam logic [CODE_W-1:0] RES_NOFIT = 2'd1;
  localparam logic [CODE_W-1:0] RES_BAD   = 2'd2;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic               clear;    // mark every partition free
    logic               load;     // write a new partition at wr_idx
    logic               grant;    // allocate the partition at wr_idx
    logic               rd_mode;  // the search token looks up rd_idx
    logic [OWNER_W-1:0] owner;    // owner written on a grant
  } cmd_t;

  // Search token that walks along the chain, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               found;
    logic               is_free;
    logic [OWNER_W-1:0] owner;
  } tok_t;

endpackage

`default_nettype wire

>>> src/bfa_cell.sv
// One partition entry of the allocator chain with its search stage.
`default_nettype none

module bfa_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int COUNT_W   = 5,
  parameter int CELL_IDX  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bfa_pkg::cmd_t        cmd,
  input  wire logic [COUNT_W-1:0]   count,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire logic [SIZE_BITS-1:0] wr_size,
  input  wire logic [SIZE_BITS-1:0] req_size,
  input  wire logic [IDX_W-1:0]     rd_idx,
  input  wire bfa_pkg::tok_t        tok_i,
  input  wire logic [IDX_W-1:0]     id_i,
  input  wire logic [SIZE_BITS-1:0] size_i,
  output bfa_pkg::tok_t             tok_o,
  output logic [IDX_W-1:0]          id_o,
  output logic [SIZE_BITS-1:0]      size_o
);
  import bfa_pkg::*;

  localparam logic [IDX_W-1:0]   MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [COUNT_W-1:0] MY_CNT = COUNT_W'(CELL_IDX);

  logic                 free_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [OWNER_W-1:0]   owner_r;

  tok_t                 tok_r, tok_nxt;
  logic [IDX_W-1:0]     id_r, id_nxt;
  logic [SIZE_BITS-1:0] tsize_r, tsize_nxt;

  logic loaded;
  logic fits;

  assign loaded = MY_CNT < count;
  assign fits   = free_r && (size_r >= req_size) && (!tok_i.found || (size_r < size_i));

  // Partition state: free mark is control, size and owner are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b1;
    end else if (cmd.clear) begin
      free_r <= 1'b1;
    end else if (cmd.load && (wr_idx == MY_IDX)) begin
      free_r <= 1'b1;
    end else if (cmd.grant && (wr_idx == MY_IDX)) begin
      free_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (wr_idx == MY_IDX)) begin
      size_r  <= wr_size;
      owner_r <= '0;
    end else if (cmd.grant && (wr_idx == MY_IDX)) begin
      size_r  <= wr_size;
      owner_r <= cmd.owner;
    end
  end

  // Search step: take over the token if this entry is the better answer, or, in read mode, the entry looked up.
  always_comb begin
    tok_nxt   = tok_i;
    id_nxt    = id_i;
    tsize_nxt = size_i;
    if (tok_i.vld && loaded) begin
      if (cmd.rd_mode) begin
        if (rd_idx == MY_IDX) begin
          tok_nxt.found   = 1'b1;
          tok_nxt.is_free = free_r;
          tok_nxt.owner   = owner_r;
          id_nxt          = MY_IDX;
          tsize_nxt       = size_r;
        end
      end else if (fits) begin
        tok_nxt.found = 1'b1;
        id_nxt        = MY_IDX;
        tsize_nxt     = size_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    tsize_r <= tsize_nxt;
  end

  assign tok_o  = tok_r;
  assign id_o   = id_r;
  assign size_o = tsize_r;

endmodule

`default_nettype wire

>>> src/best_fit_block_allocator.sv
// Top level of the best-fit partition allocator: controller and cell chain.
`default_nettype none

// Best-fit allocator over a table of up to MAX_PARTS partitions, one per cell
// of a chain. Clear and load items are answered by the controller without a
// search. Allocate and read items send a search token down the chain, one cell
// per cycle, and the result item is offered once the token leaves the last cell.
// One item is in work at a time, and a new item is taken as soon as the previous
// result leaves. Sizes are stored with SIZE_BITS bits; ties in the search go to the
// lowest id.
module best_fit_block_allocator #(
  parameter int MAX_PARTS = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0], size_value[17:2], request_id[25:18], block_index[29:26]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_code[1:0], block_id[5:2], remaining_size[21:6], is_free[22],
  // owner_id[30:23]
  output logic [31:0]      out_tdata
);
  import bfa_pkg::*;

  localparam int IDX_W   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int COUNT_W = $clog2(MAX_PARTS + 1);
  localparam int CMP_W   = (COUNT_W > BLOCK_W) ? COUNT_W : BLOCK_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                 state_r;
  logic [COUNT_W-1:0]     count_r;
  cmd_t                   cmd_r;
  logic                   launch_r;
  logic [IDX_W-1:0]       wr_idx_r;
  logic [SIZE_BITS-1:0]   wr_size_r;
  logic [SIZE_BITS-1:0]   req_r;
  logic [IDX_W-1:0]       rd_idx_r;

  logic                   out_tvalid_r;
  logic [CODE_W-1:0]      out_code_r;
  logic [BLOCK_W-1:0]     out_id_r;
  logic [FIELD_SIZE_W-1:0] out_rem_r;
  logic                   out_free_r;
  logic [OWNER_W-1:0]     out_owner_r;

  // Input fields.
  logic [ACTION_W-1:0]     in_action;
  logic [FIELD_SIZE_W-1:0] in_size;
  logic [OWNER_W-1:0]      in_req;
  logic [BLOCK_W-1:0]      in_idx;
  logic                    in_fire;
  logic [SIZE_BITS-1:0]    in_size_t;
  logic [SIZE_BITS-1:0]    grant_size;

  assign in_action = in_tdata[1:0];
  assign in_size   = in_tdata[17:2];
  assign in_req    = in_tdata[25:18];
  assign in_idx    = in_tdata[29:26];
  assign in_size_t = SIZE_BITS'(in_size);

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // Chain of cells; position 0 is fed by the controller.
  tok_t                 tok_c  [MAX_PARTS+1];
  logic [IDX_W-1:0]     id_c   [MAX_PARTS+1];
  logic [SIZE_BITS-1:0] size_c [MAX_PARTS+1];

  assign tok_c[0]  = '{vld: launch_r, found: 1'b0, is_free: 1'b0, owner: '0};
  assign id_c[0]   = '0;
  assign size_c[0] = '0;

  for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
    bfa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .COUNT_W   (COUNT_W),
      .CELL_IDX  (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd_r),
      .count    (count_r),
      .wr_idx   (wr_idx_r),
      .wr_size  (wr_size_r),
      .req_size (req_r),
      .rd_idx   (rd_idx_r),
      .tok_i    (tok_c[g]),
      .id_i     (id_c[g]),
      .size_i   (size_c[g]),
      .tok_o    (tok_c[g+1]),
      .id_o     (id_c[g+1]),
      .size_o   (size_c[g+1])
    );
  end

  assign grant_size = size_c[MAX_PARTS] - req_r;

  // Controller: decodes items, launches searches and loads the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cmd_r        <= '0;
      launch_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      cmd_r.clear <= 1'b0;
      cmd_r.load  <= 1'b0;
      cmd_r.grant <= 1'b0;
      launch_r    <= 1'b0;
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            out_code_r  <= RES_OK;
            out_id_r    <= '0;
            out_rem_r   <= '0;
            out_free_r  <= 1'b0;
            out_owner_r <= '0;
            unique case (in_action)
              ACT_CLEAR: begin
                count_r      <= '0;
                cmd_r.clear  <= 1'b1;
                out_tvalid_r <= 1'b1;
              end
              ACT_LOAD: begin
                out_tvalid_r <= 1'b1;
                if (count_r == COUNT_W'(MAX_PARTS)) begin
                  out_code_r <= RES_BAD;
                end else begin
                  cmd_r.load <= 1'b1;
                  wr_idx_r   <= IDX_W'(count_r);
                  wr_size_r  <= in_size_t;
                  count_r    <= count_r + COUNT_W'(1);
                  out_id_r   <= BLOCK_W'(count_r);
                  out_rem_r  <= FIELD_SIZE_W'(in_size_t);
                end
              end
              ACT_ALLOC: begin
                req_r         <= in_size_t;
                cmd_r.owner   <= in_req;
                cmd_r.rd_mode <= 1'b0;
                launch_r      <= 1'b1;
                state_r       <= S_SCAN;
              end
              ACT_READ: begin
                if (CMP_W'(in_idx) >= CMP_W'(count_r)) begin
                  out_code_r   <= RES_BAD;
                  out_tvalid_r <= 1'b1;
                end else begin
                  rd_idx_r      <= IDX_W'(in_idx);
                  cmd_r.rd_mode <= 1'b1;
                  launch_r      <= 1'b1;
                  state_r       <= S_SCAN;
                end
              end
              default: begin
                out_tvalid_r <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // The token leaves the last cell with the answer.
          if (tok_c[MAX_PARTS].vld) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
            if (cmd_r.rd_mode) begin
              out_id_r    <= BLOCK_W'(id_c[MAX_PARTS]);
              out_rem_r   <= FIELD_SIZE_W'(size_c[MAX_PARTS]);
              out_free_r  <= tok_c[MAX_PARTS].is_free;
              out_owner_r <= tok_c[MAX_PARTS].owner;
            end else if (!tok_c[MAX_PARTS].found) begin
              out_code_r <= RES_NOFIT;
            end else begin
              cmd_r.grant <= 1'b1;
              wr_idx_r    <= id_c[MAX_PARTS];
              wr_size_r   <= grant_size;
              out_id_r    <= BLOCK_W'(id_c[MAX_PARTS]);
              out_rem_r   <= FIELD_SIZE_W'(grant_size);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_owner_r, out_free_r, out_rem_r, out_id_r, out_code_r};

endmodule

`default_nettype wire

>>> sim/tb_best_fit_block_allocator.sv
// Self-checking testbench for the best-fit partition allocator stream block.
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;
  import bfa_pkg::*;

  localparam int NUM_PARTS    = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_EVERY   = 400;

  // One input item, first field in the lowest bits.
  typedef struct packed {
    logic [BLOCK_W-1:0]      block_index;
    logic [OWNER_W-1:0]      request_id;
    logic [FIELD_SIZE_W-1:0] size_value;
    logic [ACTION_W-1:0]     action;
  } request_t;

  // One result item, first field in the lowest bits.
  typedef struct packed {
    logic [OWNER_W-1:0]      owner_id;
    logic                    is_free;
    logic [FIELD_SIZE_W-1:0] remaining_size;
    logic [BLOCK_W-1:0]      block_id;
    logic [CODE_W-1:0]       result_code;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  best_fit_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Stimulus waiting to be sent and results waiting to be seen.
  request_t  pending_requests[$];
  response_t expected_responses[$];

  // Shadow copy of the partition table.
  logic [FIELD_SIZE_W-1:0] shadow_size  [NUM_PARTS];
  logic                    shadow_free  [NUM_PARTS];
  logic [OWNER_W-1:0]      shadow_owner [NUM_PARTS];
  int                      shadow_count;

  int  mismatches = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  int  holds_done = 0;
  int  cycle_count = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;

  // Applies one item to the shadow table and returns the result it should give.
  function automatic response_t predict_response(request_t r);
    response_t res;
    bit        found;
    int        best;
    res   = '0;
    found = 1'b0;
    best  = 0;
    unique case (r.action)
      ACT_CLEAR: begin
        shadow_count = 0;
        for (int i = 0; i < NUM_PARTS; i++) shadow_free[i] = 1'b1;
        res.result_code = RES_OK;
      end
      ACT_LOAD: begin
        if (shadow_count >= NUM_PARTS) begin
          res.result_code = RES_BAD;
        end else begin
          shadow_size[shadow_count]  = r.size_value;
          shadow_free[shadow_count]  = 1'b1;
          shadow_owner[shadow_count] = '0;
          res.result_code    = RES_OK;
          res.block_id       = BLOCK_W'(shadow_count);
          res.remaining_size = r.size_value;
          shadow_count++;
        end
      end
      ACT_ALLOC: begin
        // Smallest fitting free partition; a strict compare keeps the lowest id on ties.
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_free[i] && shadow_size[i] >= r.size_value) begin
            if (!found || shadow_size[i] < shadow_size[best]) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          res.result_code = RES_NOFIT;
        end else begin
          shadow_free[best]  = 1'b0;
          shadow_owner[best] = r.request_id;
          shadow_size[best]  = shadow_size[best] - r.size_value;
          res.result_code    = RES_OK;
          res.block_id       = BLOCK_W'(best);
          res.remaining_size = shadow_size[best];
        end
      end
      default: begin
        if (int'(r.block_index) >= shadow_count) begin
          res.result_code = RES_BAD;
        end else begin
          res.result_code    = RES_OK;
          res.block_id       = r.block_index;
          res.remaining_size = shadow_size[r.block_index];
          res.is_free        = shadow_free[r.block_index];
          res.owner_id       = shadow_owner[r.block_index];
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  task automatic push_request(input logic [ACTION_W-1:0] act, input int size,
                              input int req, input int idx);
    request_t r;
    r.action      = act;
    r.size_value  = FIELD_SIZE_W'(size);
    r.request_id  = OWNER_W'(req);
    r.block_index = BLOCK_W'(idx);
    pending_requests.push_back(r);
  endtask

  // Partition and request sizes: narrow ranges give ties, the full range gives extremes.
  function automatic int draw_size(int mode);
    unique case (mode)
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: presents items from the pending queue with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_responses.push_back(predict_response(request_t'(in_tdata[29:0])));
        if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
        send_wait = send_steady ? 0 : $urandom_range(0, 7);
      end
      if (in_tvalid && !in_tready) begin
        // Item still on offer; hold it.
      end else if (send_wait != 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, pending_requests.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks every result item and stalls at random.
  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      results_seen <= 0;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = response_t'(out_tdata[30:0]);
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = expected_responses.pop_front();
          if (got.result_code !== want.result_code)
            report_mismatch("result_code", 32'(got.result_code),
                            32'(want.result_code));
          if (got.block_id !== want.block_id)
            report_mismatch("block_id", 32'(got.block_id), 32'(want.block_id));
          if (got.remaining_size !== want.remaining_size)
            report_mismatch("remaining_size", 32'(got.remaining_size),
                            32'(want.remaining_size));
          if (got.is_free !== want.is_free)
            report_mismatch("is_free", 32'(got.is_free), 32'(want.is_free));
          if (got.owner_id !== want.owner_id)
            report_mismatch("owner_id", 32'(got.owner_id), 32'(want.owner_id));
        end
        results_seen <= results_seen + 1;
        if ($urandom_range(0, 49) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 7);
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-offs so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_seen == (holds_done + 1) * HOLD_EVERY) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int target;
    int nload;
    int nops;
    int mode;
    shadow_count = 0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      shadow_free[i]  = 1'b1;
      shadow_size[i]  = '0;
      shadow_owner[i] = '0;
    end

    // Empty table: read out of range and an allocation with nothing to fit.
    push_request(ACT_READ, 0, 0, 15);
    push_request(ACT_ALLOC, 0, 3, 0);
    push_request(ACT_CLEAR, 'hFFFF, 'hFF, 15);
    // Fill the table with extremes and tied sizes, then one load too many.
    push_request(ACT_LOAD, 'hFFFF, 0, 0);
    push_request(ACT_LOAD, 0, 0, 0);
    push_request(ACT_LOAD, 100, 0, 0);
    push_request(ACT_LOAD, 100, 0, 0);
    push_request(ACT_LOAD, 7, 0, 0);
    push_request(ACT_LOAD, 200, 0, 0);
    push_request(ACT_LOAD, 300, 0, 0);
    push_request(ACT_LOAD, 'hFFFE, 0, 0);
    push_request(ACT_LOAD, 5, 0, 0);
    push_request(ACT_LOAD, 6, 0, 0);
    push_request(ACT_LOAD, 1000, 0, 0);
    push_request(ACT_LOAD, 2000, 0, 0);
    push_request(ACT_LOAD, 3000, 0, 0);
    push_request(ACT_LOAD, 100, 0, 0);
    push_request(ACT_LOAD, 50, 0, 0);
    push_request(ACT_LOAD, 60, 0, 0);
    push_request(ACT_LOAD, 42, 0, 0);
    // Zero-sized request, a tie, the largest request and a no-fit.
    push_request(ACT_ALLOC, 0, 'hFF, 0);
    push_request(ACT_ALLOC, 100, 'h01, 0);
    push_request(ACT_ALLOC, 'hFFFF, 'hA5, 0);
    push_request(ACT_ALLOC, 'hFFFF, 'h5A, 0);
    push_request(ACT_READ, 0, 0, 2);
    push_request(ACT_READ, 0, 0, 15);
    push_request(ACT_CLEAR, 0, 0, 0);

    // Random part: mostly clear, load, then allocate and read; some noise between.
    target = pending_requests.size() + RANDOM_ITEMS;
    while (pending_requests.size() < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          push_request(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 65535),
                       $urandom_range(0, 255), $urandom_range(0, 15));
      end else begin
        mode  = $urandom_range(0, 2);
        nload = $urandom_range(1, 18);
        nops  = $urandom_range(4, 30);
        push_request(ACT_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 255),
                     $urandom_range(0, 15));
        repeat (nload)
          push_request(ACT_LOAD, draw_size(mode), $urandom_range(0, 255),
                       $urandom_range(0, 15));
        repeat (nops) begin
          if ($urandom_range(0, 2) != 0)
            push_request(ACT_ALLOC,
                         ($urandom_range(0, 9) == 0) ? 0 : draw_size(mode),
                         $urandom_range(0, 255), $urandom_range(0, 15));
          else
            push_request(ACT_READ, $urandom_range(0, 65535), $urandom_range(0, 255),
                         $urandom_range(0, 15));
        end
      end
    end

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to go out and all results to come back, then drain.
    @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_responses.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bfa_pkg.sv
src/bfa_cell.sv
src/best_fit_block_allocator.sv
sim/tb_best_fit_block_allocator.sv
